// ----- rtl/core/rfcd_pkg.sv -----
// ============================================================================
// rfcd_pkg
// Shared types, codes and constants for the receive FIFO with control decode.
// ============================================================================
package rfcd_pkg;

    localparam int DEF_BUFFER_SIZE = 64;
    localparam int CFG_ADDR_W      = 4;
    localparam int CFG_DATA_W      = 32;

    localparam logic [6:0] CH_NUL  = 7'h00;
    localparam logic [6:0] CH_ETX  = 7'h03;
    localparam logic [6:0] CH_BS   = 7'h08;
    localparam logic [6:0] CH_LF   = 7'h0A;
    localparam logic [6:0] CH_CR   = 7'h0D;
    localparam logic [6:0] CH_SO   = 7'h0E;
    localparam logic [6:0] CH_SI   = 7'h0F;
    localparam logic [6:0] CH_DC1  = 7'h11;
    localparam logic [6:0] CH_DC3  = 7'h13;
    localparam logic [6:0] CH_CAN  = 7'h18;
    localparam logic [6:0] CH_ESC  = 7'h1B;
    localparam logic [6:0] CH_SEMI = 7'h3B;
    localparam logic [6:0] CH_DEL  = 7'h7F;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_PUSHED  = 3'd0,
        ST_DROPPED = 3'd1,
        ST_CHAR    = 3'd2,
        ST_SIGNAL  = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        SIG_NONE       = 3'd0,
        SIG_KILL       = 3'd1,
        SIG_PAUSE      = 3'd2,
        SIG_RESUME     = 3'd3,
        SIG_DELETE     = 3'd4,
        SIG_SHIFTOUT   = 3'd5,
        SIG_SHIFTIN    = 3'd6,
        SIG_WOULDBLOCK = 3'd7
    } signal_code_t;

    typedef enum logic [1:0] {
        REG_ECHO_ENABLE     = 2'd0,
        REG_CRLF_ENABLE     = 2'd1,
        REG_LINE_MODE       = 2'd2,
        REG_SEMICOLON_BREAK = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_PUSHED  = 2'd0,
        KIND_DROPPED = 2'd1,
        KIND_EMPTY   = 2'd2,
        KIND_DATA    = 2'd3
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t kind;
        logic [6:0]  data;
    } queue_entry_t;

    typedef struct packed {
        logic echo_enable;
        logic crlf_enable;
        logic line_mode;
        logic semicolon_break;
    } cfg_t;

    function automatic signal_code_t classify(input logic [6:0] ch);
        signal_code_t sig;
        case (ch)
            CH_ETX, CH_CAN, CH_ESC: sig = SIG_KILL;
            CH_DC3:                 sig = SIG_PAUSE;
            CH_DC1:                 sig = SIG_RESUME;
            CH_BS, CH_DEL:          sig = SIG_DELETE;
            CH_SO:                  sig = SIG_SHIFTOUT;
            CH_SI:                  sig = SIG_SHIFTIN;
            default:                sig = SIG_NONE;
        endcase
        return sig;
    endfunction

endpackage

// ----- rtl/core/rfcd_if.sv -----
// ============================================================================
// rfcd_if
// Command and result channels of the receive FIFO with control decode.
// ============================================================================
interface rfcd_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_char;

    modport source (output valid, output opcode, output rx_char, input ready);
    modport sink   (input valid, input opcode, input rx_char, output ready);
endinterface

interface rfcd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [6:0] char_out;
    logic [2:0] signal_code;
    logic       echo_valid;
    logic [6:0] echo_char;
    logic       echo_add_cr;

    modport source (output valid, output status, output char_out, output signal_code,
                    output echo_valid, output echo_char, output echo_add_cr,
                    input ready);
    modport sink   (input valid, input status, input char_out, input signal_code,
                    input echo_valid, input echo_char, input echo_add_cr,
                    output ready);
endinterface

// ----- rtl/core/rfcd_ram.sv -----
// ============================================================================
// rfcd_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module rfcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/rfcd_front.sv -----
// ============================================================================
// rfcd_front
// Accepts push and pop commands, keeps the ring indexes and the byte memory,
// and hands one tagged entry per command to the decode queue.
// ============================================================================
module rfcd_front
    import rfcd_pkg::*;
#(
    parameter int BUFFER_SIZE = DEF_BUFFER_SIZE
) (
    input  logic         clk,
    input  logic         rst_n,
    rfcd_in_if.sink      cmd,
    output logic         q_valid,
    output queue_entry_t q_entry,
    input  logic         q_ready
);

    localparam int IDX_W = $clog2(BUFFER_SIZE);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(BUFFER_SIZE - 1);

    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] wr_slot_next, rd_slot_next;
    logic             s1_valid_reg, s1_valid_next;
    entry_kind_t      s1_kind_reg, s1_kind_next;
    logic             accept, full, empty;
    logic             ram_we, ram_re;
    logic [7:0]       ram_rdata;

    assign wr_slot_next = (wr_idx_reg == LAST_SLOT) ? '0 : wr_idx_reg + 1'b1;
    assign rd_slot_next = (rd_idx_reg == LAST_SLOT) ? '0 : rd_idx_reg + 1'b1;
    assign full         = (wr_slot_next == rd_idx_reg);
    assign empty        = (wr_idx_reg == rd_idx_reg);

    // The stage register frees up in the same cycle that the queue takes it.
    assign cmd.ready = !s1_valid_reg || q_ready;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        wr_idx_next   = wr_idx_reg;
        rd_idx_next   = rd_idx_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        s1_valid_next = s1_valid_reg && !q_ready;
        s1_kind_next  = s1_kind_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            if (opcode_t'(cmd.opcode) == OP_PUSH)
            begin
                if (full)
                begin
                    s1_kind_next = KIND_DROPPED;
                end
                else
                begin
                    s1_kind_next = KIND_PUSHED;
                    ram_we       = 1'b1;
                    wr_idx_next  = wr_slot_next;
                end
            end
            else
            begin
                if (empty)
                begin
                    s1_kind_next = KIND_EMPTY;
                end
                else
                begin
                    s1_kind_next = KIND_DATA;
                    ram_re       = 1'b1;
                    rd_idx_next  = rd_slot_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg   <= '0;
            rd_idx_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s1_kind_reg  <= KIND_PUSHED;
        end
        else
        begin
            wr_idx_reg   <= wr_idx_next;
            rd_idx_reg   <= rd_idx_next;
            s1_valid_reg <= s1_valid_next;
            s1_kind_reg  <= s1_kind_next;
        end
    end

    rfcd_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (cmd.rx_char),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign q_valid      = s1_valid_reg;
    assign q_entry.kind = s1_kind_reg;
    assign q_entry.data = ram_rdata[6:0];

endmodule

// ----- rtl/core/rfcd_queue.sv -----
// ============================================================================
// rfcd_queue
// Two-entry queue that decouples the ring front from the decode back end.
// ============================================================================
module rfcd_queue
    import rfcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    input  queue_entry_t push_entry,
    output logic         push_ready,
    output logic         pop_valid,
    output queue_entry_t pop_entry,
    input  logic         pop_ready
);

    queue_entry_t slot_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/rfcd_back.sv -----
// ============================================================================
// rfcd_back
// Decodes queued entries into status, signal, translated character and echo,
// and holds the result in an output register.
// ============================================================================
module rfcd_back
    import rfcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         q_valid,
    input  queue_entry_t q_entry,
    output logic         q_ready,
    rfcd_out_if.source   res
);

    logic         out_valid_reg, out_valid_next;
    status_t      status_reg, status_next;
    logic [6:0]   char_reg, char_next;
    signal_code_t sig_reg, sig_next;
    logic         echo_valid_reg, echo_valid_next;
    logic [6:0]   echo_char_reg, echo_char_next;
    logic         echo_cr_reg, echo_cr_next;
    signal_code_t sig_dec;
    logic [6:0]   ch_xlat;
    logic         take;

    assign q_ready = !out_valid_reg || res.ready;
    assign take    = q_valid && q_ready;
    assign sig_dec = classify(q_entry.data);

    always_comb
    begin
        ch_xlat = q_entry.data;
        if (cfg.line_mode && (q_entry.data == CH_NUL || q_entry.data == CH_CR ||
                              q_entry.data == CH_LF))
        begin
            ch_xlat = CH_LF;
        end
        else if (cfg.line_mode && cfg.semicolon_break && q_entry.data == CH_SEMI)
        begin
            ch_xlat = CH_LF;
        end
    end

    always_comb
    begin
        status_next     = ST_PUSHED;
        char_next       = '0;
        sig_next        = SIG_NONE;
        echo_valid_next = 1'b0;
        echo_char_next  = '0;
        echo_cr_next    = 1'b0;
        case (q_entry.kind)
            KIND_PUSHED:  status_next = ST_PUSHED;
            KIND_DROPPED: status_next = ST_DROPPED;
            KIND_EMPTY:
            begin
                status_next = ST_EMPTY;
                sig_next    = SIG_WOULDBLOCK;
            end
            KIND_DATA:
            begin
                if (sig_dec != SIG_NONE)
                begin
                    status_next = ST_SIGNAL;
                    sig_next    = sig_dec;
                end
                else
                begin
                    status_next = ST_CHAR;
                    char_next   = ch_xlat;
                    if (cfg.echo_enable)
                    begin
                        echo_valid_next = 1'b1;
                        echo_char_next  = ch_xlat;
                        echo_cr_next    = cfg.crlf_enable && (ch_xlat == CH_LF);
                    end
                end
            end
            default: status_next = ST_PUSHED;
        endcase
        out_valid_next = take || (out_valid_reg && !res.ready);
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg     <= status_next;
            char_reg       <= char_next;
            sig_reg        <= sig_next;
            echo_valid_reg <= echo_valid_next;
            echo_char_reg  <= echo_char_next;
            echo_cr_reg    <= echo_cr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.status      = status_reg;
    assign res.char_out    = char_reg;
    assign res.signal_code = sig_reg;
    assign res.echo_valid  = echo_valid_reg;
    assign res.echo_char   = echo_char_reg;
    assign res.echo_add_cr = echo_cr_reg;

endmodule

// ----- rtl/core/rx_fifo_control_char_decoder_unit.sv -----
// ============================================================================
// rx_fifo_control_char_decoder_unit
// Receive FIFO with control-character decode: a ring of received bytes with
// push and pop commands, where each pop is classified, translated and echoed.
//
//   Channel  Dir  Handshake            Carries
//   cmd      in   valid/ready          opcode, rx_char
//   res      out  valid/ready          status, char_out, signal_code,
//                                      echo_valid, echo_char, echo_add_cr
//   apb      in   psel/penable/pready  configuration registers 0 to 3
//
// One command is taken per cycle unless the queue stalls the front; its result
// passes through the ring memory read, a queue slot and then the output
// register. The two-entry queue lets the ring side keep accepting while the
// result side stalls. Reset clears the ring indexes, the queue and the
// output register; configuration returns to echo on, everything else off.
// ============================================================================
module rx_fifo_control_char_decoder_unit
    import rfcd_pkg::*;
#(
    parameter int BUFFER_SIZE = DEF_BUFFER_SIZE
) (
    input  logic                  clk,
    input  logic                  rst_n,
    rfcd_in_if.sink               cmd,
    rfcd_out_if.source            res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t         cfg_reg, cfg_next;
    reg_index_t   reg_idx;
    logic         cfg_write;
    logic         rd_bit;
    logic         fq_valid, fq_ready;
    queue_entry_t fq_entry;
    logic         qb_valid, qb_ready;
    queue_entry_t qb_entry;

    assign pready    = 1'b1;
    assign reg_idx   = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_idx)
                REG_ECHO_ENABLE:     cfg_next.echo_enable     = pwdata[0];
                REG_CRLF_ENABLE:     cfg_next.crlf_enable     = pwdata[0];
                REG_LINE_MODE:       cfg_next.line_mode       = pwdata[0];
                REG_SEMICOLON_BREAK: cfg_next.semicolon_break = pwdata[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ECHO_ENABLE:     rd_bit = cfg_reg.echo_enable;
            REG_CRLF_ENABLE:     rd_bit = cfg_reg.crlf_enable;
            REG_LINE_MODE:       rd_bit = cfg_reg.line_mode;
            REG_SEMICOLON_BREAK: rd_bit = cfg_reg.semicolon_break;
            default:             rd_bit = 1'b0;
        endcase
    end

    assign prdata = {{(CFG_DATA_W-1){1'b0}}, rd_bit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{echo_enable: 1'b1, crlf_enable: 1'b0,
                         line_mode: 1'b0, semicolon_break: 1'b0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rfcd_front #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (fq_valid),
        .q_entry (fq_entry),
        .q_ready (fq_ready)
    );

    rfcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_entry (fq_entry),
        .push_ready (fq_ready),
        .pop_valid  (qb_valid),
        .pop_entry  (qb_entry),
        .pop_ready  (qb_ready)
    );

    rfcd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (qb_valid),
        .q_entry (qb_entry),
        .q_ready (qb_ready),
        .res     (res)
    );

    a_empty_wouldblock: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status == ST_EMPTY) |-> (res.signal_code == SIG_WOULDBLOCK))
        else $error("Empty pop without wouldblock signal.");

    a_echo_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.echo_valid) |->
            (res.status == ST_CHAR && res.echo_char == res.char_out))
        else $error("Echo does not match returned character.");

    a_cr_only_after_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.echo_add_cr) |-> (res.echo_valid && res.echo_char == CH_LF))
        else $error("Carriage return added to something other than an echoed line feed.");

    a_signal_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status == ST_SIGNAL) |->
            (res.signal_code != SIG_NONE && res.signal_code != SIG_WOULDBLOCK))
        else $error("Control status without a control signal.");

endmodule

// ----- test/tb_rx_fifo_control_char_decoder_unit.sv -----
// ============================================================================
// tb_rx_fifo_control_char_decoder_unit
// Self-checking testbench for the receive FIFO with control-character decode.
// A queue-fed driver sends push and pop commands. Each accepted command goes
// through a local model of the ring, the classifier and the echo logic. A
// monitor compares every result transaction with the oldest prediction. The
// run covers a short directed sequence and then random fill and drain bursts
// under several register settings, with random stalls on both channels and
// one long hold on the result side.
// ============================================================================
module tb_rx_fifo_control_char_decoder_unit;
    import rfcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH     = DEF_BUFFER_SIZE;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        opcode_t    op;
        logic [7:0] data;
    } rx_cmd_t;

    typedef struct packed {
        status_t      status;
        logic [6:0]   char_out;
        signal_code_t sig;
        logic         echo_valid;
        logic [6:0]   echo_char;
        logic         echo_add_cr;
    } rx_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    rfcd_in_if  cmd_if ();
    rfcd_out_if res_if ();

    rx_cmd_t      rx_ops_to_send [$];
    rx_result_t   rx_op_results [$];
    rx_cmd_t      next_cmd;
    rx_result_t   got_result;
    rx_result_t   want_result;

    logic [7:0]   ring_mem [RING_DEPTH];
    int           wr_ptr;
    int           rd_ptr;
    signal_code_t last_signal;
    cfg_t         ctrl;

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int quiet_cycles;
    int fail_count;

    rx_fifo_control_char_decoder_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_if),
        .res     (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic rx_result_t rx_fifo_op_result(opcode_t op, logic [7:0] data);
        rx_result_t   r;
        logic [6:0]   c;
        int           nxt;
        signal_code_t s;
        r.status      = ST_PUSHED;
        r.char_out    = 7'd0;
        r.sig         = SIG_NONE;
        r.echo_valid  = 1'b0;
        r.echo_char   = 7'd0;
        r.echo_add_cr = 1'b0;
        if (op == OP_PUSH)
        begin
            nxt = (wr_ptr + 1) % RING_DEPTH;
            if (nxt == rd_ptr)
                r.status = ST_DROPPED;
            else
            begin
                ring_mem[wr_ptr] = data;
                wr_ptr = nxt;
            end
        end
        else if (rd_ptr == wr_ptr)
        begin
            r.status = ST_EMPTY;
            r.sig = SIG_WOULDBLOCK;
            last_signal = SIG_WOULDBLOCK;
        end
        else
        begin
            c = ring_mem[rd_ptr][6:0];
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            case (c)
                CH_ETX, CH_CAN, CH_ESC: s = SIG_KILL;
                CH_DC3:                 s = SIG_PAUSE;
                CH_DC1:                 s = SIG_RESUME;
                CH_BS, CH_DEL:          s = SIG_DELETE;
                CH_SO:                  s = SIG_SHIFTOUT;
                CH_SI:                  s = SIG_SHIFTIN;
                default:                s = SIG_NONE;
            endcase
            if (s != SIG_NONE)
            begin
                r.status = ST_SIGNAL;
                r.sig = s;
                last_signal = s;
            end
            else
            begin
                if (ctrl.line_mode && (c == CH_NUL || c == CH_CR || c == CH_LF))
                    c = CH_LF;
                else if (ctrl.line_mode && ctrl.semicolon_break && c == CH_SEMI)
                    c = CH_LF;
                r.status = ST_CHAR;
                r.char_out = c;
                if (ctrl.echo_enable)
                begin
                    r.echo_valid = 1'b1;
                    r.echo_char = c;
                    r.echo_add_cr = ctrl.crlf_enable && (c == CH_LF);
                end
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] next_rx_byte();
        logic [6:0] c;
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom);
        case ($urandom_range(0, 12))
            0:       c = CH_NUL;
            1:       c = CH_ETX;
            2:       c = CH_BS;
            3:       c = CH_LF;
            4:       c = CH_CR;
            5:       c = CH_SO;
            6:       c = CH_SI;
            7:       c = CH_DC1;
            8:       c = CH_DC3;
            9:       c = CH_CAN;
            10:      c = CH_ESC;
            11:      c = CH_SEMI;
            default: c = CH_DEL;
        endcase
        return {($urandom_range(0, 3) == 0), c};
    endfunction

    task automatic send_op(opcode_t op, logic [7:0] data);
        rx_cmd_t item;
        item.op = op;
        item.data = data;
        rx_ops_to_send.push_back(item);
    endtask

    task automatic queue_traffic(int n_items);
        int count;
        int burst;
        int mode;
        repeat (RING_DEPTH + 6) send_op(OP_PUSH, next_rx_byte());
        repeat (RING_DEPTH + 6) send_op(OP_POP, 8'($urandom));
        count = 2 * (RING_DEPTH + 6);
        while (count < n_items)
        begin
            mode = $urandom_range(0, 9);
            burst = $urandom_range(1, 70);
            repeat (burst)
            begin
                if (mode < 4)
                    send_op(OP_PUSH, next_rx_byte());
                else if (mode < 8)
                    send_op(OP_POP, 8'($urandom));
                else
                    send_op(opcode_t'($urandom_range(0, 1)), next_rx_byte());
            end
            count += burst;
        end
    endtask

    // Checked at the falling edge, once every update of the rising edge has settled.
    task automatic wait_drained();
        @(negedge clk);
        while (rx_ops_to_send.size() != 0 || cmd_if.valid || rx_op_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(reg_index_t idx, logic value);
        logic [CFG_DATA_W-1:0] data;
        data = $urandom;
        data[0] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_ECHO_ENABLE:     ctrl.echo_enable = value;
            REG_CRLF_ENABLE:     ctrl.crlf_enable = value;
            REG_LINE_MODE:       ctrl.line_mode = value;
            REG_SEMICOLON_BREAK: ctrl.semicolon_break = value;
            default:             ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(logic echo, logic crlf, logic line, logic semi);
        cfg_write(REG_ECHO_ENABLE, echo);
        cfg_write(REG_CRLF_ENABLE, crlf);
        cfg_write(REG_LINE_MODE, line);
        cfg_write(REG_SEMICOLON_BREAK, semi);
    endtask

    task automatic report_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_if.valid && cmd_if.ready)
                rx_op_results.push_back(rx_fifo_op_result(opcode_t'(cmd_if.opcode),
                                                          cmd_if.rx_char));
            if (!cmd_if.valid || cmd_if.ready)
            begin
                if (rx_ops_to_send.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    next_cmd = rx_ops_to_send.pop_front();
                    cmd_if.valid   <= 1'b1;
                    cmd_if.opcode  <= next_cmd.op;
                    cmd_if.rx_char <= next_cmd.data;
                end
                else
                    cmd_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                got_result.status      = status_t'(res_if.status);
                got_result.char_out    = res_if.char_out;
                got_result.sig         = signal_code_t'(res_if.signal_code);
                got_result.echo_valid  = res_if.echo_valid;
                got_result.echo_char   = res_if.echo_char;
                got_result.echo_add_cr = res_if.echo_add_cr;
                if (rx_op_results.size() == 0)
                    report_failure($sformatf("ERROR: unexpected result transaction status=%0d",
                                             got_result.status));
                else
                begin
                    want_result = rx_op_results.pop_front();
                    if (got_result.status !== want_result.status
                        || got_result.char_out !== want_result.char_out
                        || got_result.sig !== want_result.sig
                        || got_result.echo_valid !== want_result.echo_valid
                        || got_result.echo_char !== want_result.echo_char
                        || got_result.echo_add_cr !== want_result.echo_add_cr)
                        report_failure($sformatf({"ERROR: result mismatch ",
                            "exp status=%0d char=%02h sig=%0d echo=%b/%02h/%b ",
                            "got status=%0d char=%02h sig=%0d echo=%b/%02h/%b"},
                            want_result.status, want_result.char_out, want_result.sig,
                            want_result.echo_valid, want_result.echo_char,
                            want_result.echo_add_cr,
                            got_result.status, got_result.char_out, got_result.sig,
                            got_result.echo_valid, got_result.echo_char,
                            got_result.echo_add_cr));
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                res_if.ready <= 1'b0;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served <= hold_served + 1;
                hold_left <= HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("rx_fifo_control_char_decoder_unit test failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.opcode  = OP_PUSH;
        cmd_if.rx_char = 8'h00;
        res_if.ready   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        wr_ptr         = 0;
        rd_ptr         = 0;
        last_signal    = SIG_NONE;
        ctrl.echo_enable     = 1'b1;
        ctrl.crlf_enable     = 1'b0;
        ctrl.line_mode       = 1'b0;
        ctrl.semicolon_break = 1'b0;
        tx_idle_pct    = 33;
        rx_idle_pct    = 50;
        hold_requests  = 0;
        hold_served    = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        fail_count     = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Pop on the empty ring, then every control code, NUL, CR and a
        // high-bit DEL under the reset settings, then drain past empty.
        send_op(OP_POP, 8'hFF);
        send_op(OP_PUSH, {1'b0, CH_NUL});
        send_op(OP_PUSH, {1'b0, CH_ETX});
        send_op(OP_PUSH, {1'b0, CH_BS});
        send_op(OP_PUSH, {1'b0, CH_CR});
        send_op(OP_PUSH, {1'b0, CH_SO});
        send_op(OP_PUSH, {1'b0, CH_SI});
        send_op(OP_PUSH, {1'b0, CH_DC1});
        send_op(OP_PUSH, {1'b0, CH_DC3});
        send_op(OP_PUSH, {1'b0, CH_CAN});
        send_op(OP_PUSH, {1'b0, CH_ESC});
        send_op(OP_PUSH, 8'hFF);
        repeat (12) send_op(OP_POP, 8'h00);
        wait_drained();

        apply_settings(1'b1, 1'b1, 1'b1, 1'b1);
        queue_traffic(230);
        wait_drained();

        tx_idle_pct = 50;
        rx_idle_pct = 33;
        apply_settings(1'b0, 1'b0, 1'b0, 1'b0);
        queue_traffic(230);
        wait_drained();

        apply_settings(1'b1, 1'b1, 1'b1, 1'b0);
        queue_traffic(230);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_settings(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        queue_traffic(230);
        hold_requests = hold_requests + 1;
        wait_drained();

        apply_settings(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        queue_traffic(230);
        wait_drained();

        apply_settings(1'b0, 1'b1, 1'b1, 1'b1);
        queue_traffic(200);
        wait_drained();

        if (fail_count == 0 && rx_op_results.size() == 0)
            $display("rx_fifo_control_char_decoder_unit test passed");
        else
            $display("rx_fifo_control_char_decoder_unit test failed");
        $finish;
    end

endmodule
